>>> src/strip_hit_record_deframer_unit_assert.svh
// ----------------------------------------------------------------------------
// Strip hit record deframer assertion macros
// Short forms for the concurrent checks of the deframer, clocked on the
// rising edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef STRIP_HIT_RECORD_DEFRAMER_UNIT_ASSERT_SVH
`define STRIP_HIT_RECORD_DEFRAMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHRD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define SHRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed in the next cycle");

`endif

>>> src/shrd_pkg.sv
// ----------------------------------------------------------------------------
// Strip hit record deframer package
// Transfer types, framing constants and the record unpack function.
// ----------------------------------------------------------------------------
package shrd_pkg;

  // Header length of each event in bytes, and record framing.
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] HEADER_BYTES = 4'd10;
  localparam int unsigned RECORD_BYTES = 10;
  localparam logic [POS_W-1:0] REC_LAST = 4'(RECORD_BYTES - 1);

  typedef logic [RECORD_BYTES-1:0][7:0] shrd_record_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_event;
    logic [63:0] event_timestamp;
  } shrd_in_t;

  typedef struct packed {
    logic [7:0]         strip_channel;
    logic signed [15:0] sample_zero;
    logic signed [15:0] sample_one;
    logic signed [15:0] sample_two;
    logic [2:0]         chip_id;
    logic [2:0]         hybrid_number;
    logic [3:0]         board_number;
    logic [5:0]         trigger_count;
    logic [3:0]         status_flags;
    logic [63:0]        hit_timestamp;
  } shrd_out_t;

  // Splits one stored record into its hit fields.
  function automatic shrd_out_t shrd_unpack(shrd_record_t rec, logic [63:0] ts);
    shrd_out_t res;
    res.strip_channel = rec[6];
    res.sample_zero   = $signed({rec[1], rec[0]});
    res.sample_one    = $signed({rec[3], rec[2]});
    res.sample_two    = $signed({rec[5], rec[4]});
    res.chip_id       = rec[7][2:0];
    res.hybrid_number = rec[7][6:4];
    res.board_number  = rec[8][3:0];
    res.trigger_count = {rec[9][1:0], rec[8][7:4]};
    res.status_flags  = rec[9][5:2];
    res.hit_timestamp = ts;
    return res;
  endfunction

endpackage

>>> src/shrd_in_stage.sv
// ----------------------------------------------------------------------------
// Deframer input stage
// Registers each incoming byte transfer ahead of the framing logic.
// ----------------------------------------------------------------------------
module shrd_in_stage import shrd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  shrd_in_t in_data_i,
  input  logic     out_free_i,
  output logic     s1_valid_o,
  output logic     s1_fire_o,
  output shrd_in_t s1_data_o
);

  logic     valid_q, valid_d;
  shrd_in_t data_q;

  // The held byte moves on whenever the result register can take its outcome.
  assign s1_fire_o  = valid_q && out_free_i;
  assign in_stall_o = valid_q && !out_free_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_data_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_data_o  = data_q;

endmodule

>>> src/shrd_core.sv
// ----------------------------------------------------------------------------
// Deframer framing core
// Header skip, record gathering, one-record hold back and timestamp latch.
// ----------------------------------------------------------------------------
module shrd_core import shrd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  shrd_in_t  item_i,
  output logic      emit_o,
  output shrd_out_t result_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             in_payload_q, in_payload_d;
  logic             held_valid_q, held_valid_d;
  logic             first_q, first_d;
  logic [63:0]      time_q, time_d;
  shrd_record_t     gather_q, held_q;

  logic             hdr_byte;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] rec_pos;
  logic             rec_done;

  assign hdr_byte = !in_payload_q && (pos_q < HEADER_BYTES);
  assign pos_inc  = pos_q + 4'd1;
  // Position inside the record; the first payload byte after the header is zero.
  assign rec_pos  = (!in_payload_q || pos_q >= 4'(RECORD_BYTES)) ? '0 : pos_q;
  assign rec_done = !hdr_byte && (rec_pos == REC_LAST);

  always_comb begin
    pos_d        = pos_q;
    in_payload_d = in_payload_q;
    held_valid_d = held_valid_q;
    first_d      = first_q;
    time_d       = first_q ? item_i.event_timestamp : time_q;
    if (first_q) begin
      first_d = 1'b0;
    end
    if (hdr_byte) begin
      in_payload_d = (pos_inc == HEADER_BYTES);
      pos_d        = in_payload_d ? '0 : pos_inc;
    end else begin
      in_payload_d = 1'b1;
      if (rec_done) begin
        held_valid_d = 1'b1;
        pos_d        = '0;
      end else begin
        pos_d = rec_pos + 4'd1;
      end
    end
    if (item_i.end_of_event) begin
      pos_d        = '0;
      in_payload_d = 1'b0;
      held_valid_d = 1'b0;
      first_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      in_payload_q <= 1'b0;
      held_valid_q <= 1'b0;
      first_q      <= 1'b1;
      time_q       <= '0;
    end else if (fire_i) begin
      pos_q        <= pos_d;
      in_payload_q <= in_payload_d;
      held_valid_q <= held_valid_d;
      first_q      <= first_d;
      time_q       <= time_d;
    end
  end

  // Every record position is rewritten before a record is copied, so the
  // gather and hold registers need no clearing.
  always_ff @(posedge clk_i) begin
    if (fire_i && !hdr_byte) begin
      for (int i = 0; i < RECORD_BYTES; i++) begin
        if (rec_pos == 4'(i)) begin
          gather_q[i] <= item_i.data_byte;
        end
      end
      if (rec_done) begin
        held_q <= {item_i.data_byte, gather_q[RECORD_BYTES-2:0]};
      end
    end
  end

  assign emit_o   = rec_done && held_valid_q;
  assign result_o = shrd_unpack(held_q, time_d);

endmodule

>>> src/shrd_out_stage.sv
// ----------------------------------------------------------------------------
// Deframer result stage
// Holds one unpacked hit until the downstream side takes it.
// ----------------------------------------------------------------------------
module shrd_out_stage import shrd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  logic      emit_i,
  input  shrd_out_t result_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output shrd_out_t out_data_o
);

  logic      valid_q, valid_d;
  shrd_out_t data_q;

  assign out_free_o = !valid_q || !out_stall_i;
  assign valid_d    = out_free_o ? (load_i && emit_i) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && load_i && emit_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> src/strip_hit_record_deframer_unit.sv
// ----------------------------------------------------------------------------
// Strip hit record deframer
// Turns a byte stream of strip readout events into unpacked hit records.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while its input is not stalled. Every
// byte is registered at the input and passes through the framing logic once
// the result register can take its outcome. When it completes a record, it
// loads the result register, so a hit is presented there once the byte that
// finishes the record after it has left the input register. The only thing
// that slows the input is a stalled result: the input stalls exactly while a
// hit waits in the result register, the downstream side stalls it, and a
// byte already waits in the input register. Each event opens with a fixed
// header that is skipped, then 10-byte records follow. A finished record is
// held back and is only delivered once the next record of the same event is
// complete, so the last full record of every event is dropped, as are
// trailing partial records and events that end inside the header. The
// timestamp of the event's first byte is attached to all its hits.
module strip_hit_record_deframer_unit import shrd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  shrd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output shrd_out_t out_data_o
);

`include "strip_hit_record_deframer_unit_assert.svh"

  logic      out_free;
  logic      s1_valid;
  logic      s1_fire;
  shrd_in_t  s1_data;
  logic      core_emit;
  shrd_out_t core_result;

  // Input register: one byte transfer in flight ahead of the framing logic.
  shrd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_free_i (out_free),
    .s1_valid_o (s1_valid),
    .s1_fire_o  (s1_fire),
    .s1_data_o  (s1_data)
  );

  // Framing state advances once for every byte that leaves the input register.
  shrd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .item_i   (s1_data),
    .emit_o   (core_emit),
    .result_o (core_result)
  );

  // Result register toward the downstream side.
  shrd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire),
    .emit_i      (core_emit),
    .result_i    (core_result),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The input only stalls because a hit is held up downstream.
  `SHRD_ASSERT_SAME(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  // A byte that completes a record with one held back must deliver a hit.
  `SHRD_ASSERT_NEXT(a_emit_lands, clk_i, rst_ni, s1_fire && core_emit, out_valid_o)
  // An accepted byte transfer is present in the input register next cycle.
  `SHRD_ASSERT_NEXT(a_in_taken, clk_i, rst_ni, in_valid_i && !in_stall_o, s1_valid)

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Strip hit record deframer testbench
// Streams strip readout events byte by byte into the deframer. It predicts
// each hit from a local model of the header skip, record gathering and
// hold-back, and checks every delivered hit field by field. Both sides
// idle at random, with a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb;
  import shrd_pkg::*;

  // Clock and reset. The reset is asserted once, at the start of the run.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Both channels start out idle with known values.
  logic      in_valid = 1'b0;
  logic      in_stall;
  shrd_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  shrd_out_t out_data;

  strip_hit_record_deframer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Local copy of the deframer state, updated once per accepted byte.
  logic [POS_W-1:0] rec_pos     = '0;
  bit               past_header = 1'b0;
  shrd_record_t     gather_rec  = '0;
  shrd_record_t     held_rec    = '0;
  bit               held_ok     = 1'b0;
  logic [63:0]      event_time  = '0;
  bit               await_first = 1'b1;

  // Hits that have been predicted but not yet delivered, oldest first.
  shrd_out_t hits_due[$];
  shrd_out_t seen_hit;
  shrd_out_t want_hit;

  // Run controls shared by the stimulus, the receiver and the checker.
  bit idle_on   = 1'b1;
  int hold_len  = 0;
  int fail_count   = 0;
  int bytes_sent   = 0;
  int events_sent  = 0;
  int hits_checked = 0;
  int holds_done   = 0;
  int stall_cycles = 0;

  // Number of idle cycles before the next transfer of either side. Half of
  // the draws give no idling at all, so back-to-back transfers are common.
  function automatic int draw_wait();
    if (!idle_on) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 11);
  endfunction

  // Advances the local deframer by one byte. The header is counted off
  // first, then bytes fill a record. A full record replaces the held one,
  // and the previously held record, if any, comes out as a hit. The end
  // mark is applied after the byte itself, so the last byte may still
  // complete a record and release the held one.
  function automatic bit deframe_byte(input shrd_in_t item, output shrd_out_t hit);
    logic [15:0] tail_word;
    bit          got;
    bit          in_hdr;
    got    = 1'b0;
    in_hdr = 1'b0;
    hit    = '0;
    // The timestamp belongs to the first byte of the event only.
    if (await_first) begin
      event_time  = item.event_timestamp;
      await_first = 1'b0;
    end
    if (!past_header) begin
      if (rec_pos < HEADER_BYTES) begin
        in_hdr  = 1'b1;
        rec_pos = rec_pos + 1'b1;
        if (rec_pos == HEADER_BYTES) begin
          past_header = 1'b1;
          rec_pos     = '0;
        end
      end else begin
        past_header = 1'b1;
        rec_pos     = '0;
      end
    end
    if (past_header && !in_hdr) begin
      if (rec_pos >= RECORD_BYTES) rec_pos = '0;
      gather_rec[rec_pos] = item.data_byte;
      rec_pos = rec_pos + 1'b1;
      if (rec_pos == RECORD_BYTES) begin
        if (held_ok) begin
          // Bytes 8 and 9 form one little-endian word holding the board id,
          // the trigger count and the status flags.
          tail_word         = {held_rec[9], held_rec[8]};
          hit.strip_channel = held_rec[6];
          hit.sample_zero   = {held_rec[1], held_rec[0]};
          hit.sample_one    = {held_rec[3], held_rec[2]};
          hit.sample_two    = {held_rec[5], held_rec[4]};
          hit.chip_id       = held_rec[7][2:0];
          hit.hybrid_number = held_rec[7][6:4];
          hit.board_number  = tail_word[3:0];
          hit.trigger_count = tail_word[9:4];
          hit.status_flags  = tail_word[13:10];
          hit.hit_timestamp = event_time;
          got = 1'b1;
        end
        held_rec   = gather_rec;
        held_ok    = 1'b1;
        gather_rec = '0;
        rec_pos    = '0;
      end
    end
    // The end mark drops the held record and any partial one. The latched
    // timestamp is kept until the next event's first byte.
    if (item.end_of_event) begin
      rec_pos     = '0;
      past_header = 1'b0;
      gather_rec  = '0;
      held_rec    = '0;
      held_ok     = 1'b0;
      await_first = 1'b1;
    end
    return got;
  endfunction

  // Every failure goes through here: one line, and the count goes up.
  task automatic note_failure(input string msg);
    fail_count++;
    $display("MISMATCH: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      note_failure($sformatf("hit %0d %s got %h expected %h", hits_checked, name, got, want));
  endtask

  // Offers one byte after a random gap, holds it steady until the block
  // takes it, then feeds the same byte to the local model. The task is
  // entered and left right after a rising edge, and valid stays high on
  // return so a following byte can go out with no bubble.
  task automatic offer_byte(input logic [7:0] b, input bit last, input logic [63:0] ts);
    shrd_in_t  item;
    shrd_out_t hit;
    int        gap;
    item.data_byte       = b;
    item.end_of_event    = last;
    item.event_timestamp = ts;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (deframe_byte(item, hit)) hits_due.insert(hits_due.size(), hit);
    bytes_sent++;
  endtask

  // Sends one event of the given length with random content, biased toward
  // the extreme byte values that exercise the sign of the samples. Every
  // byte carries a fresh timestamp, so only the first one may be latched.
  task automatic send_event(input int len);
    logic [7:0]  b;
    logic [63:0] ts;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0: b = 8'h00;
        1: b = 8'hFF;
        2: b = 8'h80;
        3: b = 8'h7F;
        default: b = 8'($urandom);
      endcase
      ts = {$urandom, $urandom};
      if (i == 0 && $urandom_range(0, 7) == 0) ts = $urandom_range(0, 1) ? '1 : '0;
      offer_byte(b, i == len - 1, ts);
    end
    events_sent++;
  endtask

  // Lowers valid and waits until every predicted hit has been delivered,
  // then goes on waiting so that a stray hit would still show up.
  task automatic wait_hits_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (hits_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // An event that ends inside the header must give nothing.
  task automatic test_short_event();
    offer_byte(8'hFF, 1'b0, '1);
    offer_byte(8'h00, 1'b0, '0);
    offer_byte(8'h5A, 1'b1, '0);
  endtask

  // Header, a record of all ones, then a record of all zeros whose last byte
  // carries the end mark. That byte completes the second record and releases
  // the first one, which must come out with every field all ones and
  // the all-ones timestamp; the zero record is dropped with the event.
  task automatic test_extreme_record();
    for (int i = 0; i < int'(HEADER_BYTES); i++)
      offer_byte(8'($urandom), 1'b0, (i == 0) ? '1 : 64'h0);
    for (int i = 0; i < RECORD_BYTES; i++) offer_byte(8'hFF, 1'b0, '0);
    for (int i = 0; i < RECORD_BYTES; i++) offer_byte(8'h00, i == RECORD_BYTES - 1, '0);
  endtask

  // Mostly well-formed events with one to five records and sometimes a
  // trailing partial record, mixed with events cut short inside the header
  // and events of arbitrary length.
  task automatic test_random_events(input int budget);
    int stop_at;
    int len;
    int kind;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        len = $urandom_range(1, int'(HEADER_BYTES));
      end else if (kind == 1) begin
        len = $urandom_range(11, 60);
      end else begin
        len = int'(HEADER_BYTES) + RECORD_BYTES * $urandom_range(1, 5);
        if ($urandom_range(0, 2) == 0) len += $urandom_range(1, RECORD_BYTES - 1);
      end
      send_event(len);
    end
  endtask

  // The sender stops and waits for every hit before it goes on.
  task automatic test_drain_pause();
    send_event(int'(HEADER_BYTES) + 3 * RECORD_BYTES);
    wait_hits_drained();
    send_event(int'(HEADER_BYTES) + 4 * RECORD_BYTES + 3);
  endtask

  // The receiver holds off for a long stretch after its next transfer while
  // the sender streams a long event with no gaps, so the result side backs
  // up and the block has to stall its input.
  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_len = 200;
    send_event(int'(HEADER_BYTES) + 8 * RECORD_BYTES);
    idle_on  = 1'b1;
    wait_hits_drained();
  endtask

  // Back-to-back transfers on both sides for a stretch.
  task automatic test_no_idle(input int budget);
    idle_on = 1'b0;
    test_random_events(budget);
    idle_on = 1'b1;
  endtask

  // Receiver: draws a stall length per hit, or takes a requested long
  // hold-off, then keeps stall low until the next transfer.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      n = draw_wait();
      if (hold_len != 0) begin
        n        = hold_len;
        hold_len = 0;
        holds_done++;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Checker: every hit transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      seen_hit = out_data;
      if (hits_due.size() == 0) begin
        note_failure($sformatf("hit delivered with none expected: %h", seen_hit));
      end else begin
        want_hit = hits_due.pop_front();
        compare_field("strip_channel", 64'(seen_hit.strip_channel),
                      64'(want_hit.strip_channel));
        compare_field("sample_zero", 64'(seen_hit.sample_zero),
                      64'(want_hit.sample_zero));
        compare_field("sample_one", 64'(seen_hit.sample_one),
                      64'(want_hit.sample_one));
        compare_field("sample_two", 64'(seen_hit.sample_two),
                      64'(want_hit.sample_two));
        compare_field("chip_id", 64'(seen_hit.chip_id),
                      64'(want_hit.chip_id));
        compare_field("hybrid_number", 64'(seen_hit.hybrid_number),
                      64'(want_hit.hybrid_number));
        compare_field("board_number", 64'(seen_hit.board_number),
                      64'(want_hit.board_number));
        compare_field("trigger_count", 64'(seen_hit.trigger_count),
                      64'(want_hit.trigger_count));
        compare_field("status_flags", 64'(seen_hit.status_flags),
                      64'(want_hit.status_flags));
        compare_field("hit_timestamp", seen_hit.hit_timestamp, want_hit.hit_timestamp);
      end
      hits_checked++;
    end
  end

  // Main sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_event();
    test_extreme_record();
    wait_hits_drained();
    test_random_events(1100);
    test_drain_pause();
    test_backpressure();
    test_no_idle(400);
    test_random_events(400);

    // Wait for the last hits, with a bound, then let the clock run on.
    in_valid <= 1'b0;
    for (int k = 0; k < 5000 && hits_due.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    while (hits_due.size() != 0) begin
      want_hit = hits_due.pop_front();
      note_failure($sformatf("expected hit never delivered: %h", want_hit));
    end

    $display("Sent %0d events in %0d bytes and checked %0d hits.",
             events_sent, bytes_sent, hits_checked);
    $display("Input held off by the block on %0d cycles; %0d long receiver hold-offs.",
             stall_cycles, holds_done);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
